[hw/rtl/aabb_pkg.sv]
package aabb_pkg;

    localparam int COORD_BITS_DEFAULT = 16;
    localparam int FIFO_DEPTH = 2;
    localparam int BOX_FIELDS = 6;
    localparam int AXES = 3;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_ROOT = 4'b0100,
        ST_DONE = 4'b1000
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

[hw/rtl/aabb_front.sv]
module aabb_front #(
    parameter int COORD_BITS = aabb_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           s_valid,
    output logic                                           s_ready,
    input  logic signed [COORD_BITS-1:0]                   s_pos_x,
    input  logic signed [COORD_BITS-1:0]                   s_pos_y,
    input  logic signed [COORD_BITS-1:0]                   s_pos_z,
    input  logic                                           s_last_vertex,
    input  aabb_pkg::fifo_status_t                         fifo_status,
    output logic                                           push_valid,
    output logic [aabb_pkg::BOX_FIELDS*COORD_BITS-1:0]     push_data
);

    localparam int W = COORD_BITS;

    logic signed [W-1:0] lo_x_reg, lo_y_reg, lo_z_reg;
    logic signed [W-1:0] hi_x_reg, hi_y_reg, hi_z_reg;
    logic signed [W-1:0] lo_x_next, lo_y_next, lo_z_next;
    logic signed [W-1:0] hi_x_next, hi_y_next, hi_z_next;
    logic                first_reg;
    logic                accept;

    assign s_ready = !fifo_status.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        if (first_reg) begin
            lo_x_next = s_pos_x;
            lo_y_next = s_pos_y;
            lo_z_next = s_pos_z;
            hi_x_next = s_pos_x;
            hi_y_next = s_pos_y;
            hi_z_next = s_pos_z;
        end else begin
            lo_x_next = (s_pos_x < lo_x_reg) ? s_pos_x : lo_x_reg;
            lo_y_next = (s_pos_y < lo_y_reg) ? s_pos_y : lo_y_reg;
            lo_z_next = (s_pos_z < lo_z_reg) ? s_pos_z : lo_z_reg;
            hi_x_next = (s_pos_x > hi_x_reg) ? s_pos_x : hi_x_reg;
            hi_y_next = (s_pos_y > hi_y_reg) ? s_pos_y : hi_y_reg;
            hi_z_next = (s_pos_z > hi_z_reg) ? s_pos_z : hi_z_reg;
        end
    end

    assign push_valid = accept && s_last_vertex;
    assign push_data  = {hi_z_next, hi_y_next, hi_x_next, lo_z_next, lo_y_next, lo_x_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
            lo_x_reg  <= '0;
            lo_y_reg  <= '0;
            lo_z_reg  <= '0;
            hi_x_reg  <= '0;
            hi_y_reg  <= '0;
            hi_z_reg  <= '0;
        end else if (accept) begin
            first_reg <= s_last_vertex;
            lo_x_reg  <= lo_x_next;
            lo_y_reg  <= lo_y_next;
            lo_z_reg  <= lo_z_next;
            hi_x_reg  <= hi_x_next;
            hi_y_reg  <= hi_y_next;
            hi_z_reg  <= hi_z_next;
        end
    end

endmodule

[hw/rtl/aabb_fifo.sv]
module aabb_fifo #(
    parameter int DATA_BITS = aabb_pkg::BOX_FIELDS * aabb_pkg::COORD_BITS_DEFAULT,
    parameter int DEPTH     = aabb_pkg::FIFO_DEPTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  logic [DATA_BITS-1:0]    push_data,
    input  logic                    pop,
    output logic [DATA_BITS-1:0]    pop_data,
    output aabb_pkg::fifo_status_t  status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [PW-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]        count_reg;
    logic                 do_push, do_pop;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && status.full))
        else $error("item pushed into full queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue count out of range");

endmodule

[hw/rtl/aabb_back.sv]
module aabb_back #(
    parameter int COORD_BITS = aabb_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  aabb_pkg::fifo_status_t                         fifo_status,
    input  logic [aabb_pkg::BOX_FIELDS*COORD_BITS-1:0]     box_data,
    output logic                                           pop,
    output logic                                           m_valid,
    input  logic                                           m_ready,
    output logic signed [COORD_BITS-1:0]                   m_center_x,
    output logic signed [COORD_BITS-1:0]                   m_center_y,
    output logic signed [COORD_BITS-1:0]                   m_center_z,
    output logic        [COORD_BITS-1:0]                   m_radius,
    output logic signed [COORD_BITS-1:0]                   m_box_min_x,
    output logic signed [COORD_BITS-1:0]                   m_box_min_y,
    output logic signed [COORD_BITS-1:0]                   m_box_min_z,
    output logic signed [COORD_BITS-1:0]                   m_box_max_x,
    output logic signed [COORD_BITS-1:0]                   m_box_max_y,
    output logic signed [COORD_BITS-1:0]                   m_box_max_z
);

    localparam int W  = COORD_BITS;
    localparam int CW = $clog2(W);
    localparam logic [CW-1:0] MUL_LAST = CW'(aabb_pkg::AXES);

    aabb_pkg::back_state_t state_reg;

    logic signed [W-1:0] in_lo_x, in_lo_y, in_lo_z, in_hi_x, in_hi_y, in_hi_z;
    logic signed [W:0]   ext_x_w, ext_y_w, ext_z_w;
    logic signed [W:0]   sum_x_w, sum_y_w, sum_z_w;

    logic signed [W-1:0] lo_x_reg, lo_y_reg, lo_z_reg, hi_x_reg, hi_y_reg, hi_z_reg;
    logic signed [W-1:0] cen_x_reg, cen_y_reg, cen_z_reg;
    logic [W-1:0]        ext_x_reg, ext_y_reg, ext_z_reg;
    logic [CW-1:0]       cnt_reg;
    logic [W-1:0]        esel;
    logic [2*W-1:0]      sq_next, sq_reg;
    logic [2*W+1:0]      acc_reg, acc_next;
    logic [2*W-1:0]      n_reg;
    logic [W+1:0]        rem_reg, rem_shift, trial;
    logic [W-1:0]        root_reg;
    logic                m_valid_reg;
    logic                out_free;

    assign {in_hi_z, in_hi_y, in_hi_x, in_lo_z, in_lo_y, in_lo_x} = box_data;

    assign ext_x_w = {in_hi_x[W-1], in_hi_x} - {in_lo_x[W-1], in_lo_x};
    assign ext_y_w = {in_hi_y[W-1], in_hi_y} - {in_lo_y[W-1], in_lo_y};
    assign ext_z_w = {in_hi_z[W-1], in_hi_z} - {in_lo_z[W-1], in_lo_z};
    assign sum_x_w = {in_hi_x[W-1], in_hi_x} + {in_lo_x[W-1], in_lo_x};
    assign sum_y_w = {in_hi_y[W-1], in_hi_y} + {in_lo_y[W-1], in_lo_y};
    assign sum_z_w = {in_hi_z[W-1], in_hi_z} + {in_lo_z[W-1], in_lo_z};

    assign pop = (state_reg == aabb_pkg::ST_IDLE) && !fifo_status.empty;

    always_comb begin
        priority if (cnt_reg == '0) begin
            esel = ext_x_reg;
        end else if (cnt_reg == CW'(1)) begin
            esel = ext_y_reg;
        end else begin
            esel = ext_z_reg;
        end
    end

    assign sq_next   = {{W{1'b0}}, esel} * {{W{1'b0}}, esel};
    assign acc_next  = acc_reg + {2'b00, sq_reg};
    assign rem_shift = {rem_reg[W-1:0], n_reg[2*W-1:2*W-2]};
    assign trial     = {root_reg, 2'b01};
    assign out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= aabb_pkg::ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            priority if (state_reg == aabb_pkg::ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                aabb_pkg::ST_IDLE: begin
                    if (pop) begin
                        cnt_reg   <= '0;
                        state_reg <= aabb_pkg::ST_MUL;
                    end
                end
                aabb_pkg::ST_MUL: begin
                    if (cnt_reg == MUL_LAST) begin
                        cnt_reg   <= CW'(W - 1);
                        state_reg <= aabb_pkg::ST_ROOT;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                aabb_pkg::ST_ROOT: begin
                    if (cnt_reg == '0) begin
                        state_reg <= aabb_pkg::ST_DONE;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                aabb_pkg::ST_DONE: begin
                    if (out_free) begin
                        state_reg <= aabb_pkg::ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= aabb_pkg::ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            lo_x_reg  <= in_lo_x;
            lo_y_reg  <= in_lo_y;
            lo_z_reg  <= in_lo_z;
            hi_x_reg  <= in_hi_x;
            hi_y_reg  <= in_hi_y;
            hi_z_reg  <= in_hi_z;
            ext_x_reg <= ext_x_w[W-1:0];
            ext_y_reg <= ext_y_w[W-1:0];
            ext_z_reg <= ext_z_w[W-1:0];
            cen_x_reg <= sum_x_w[W:1];
            cen_y_reg <= sum_y_w[W:1];
            cen_z_reg <= sum_z_w[W:1];
            acc_reg   <= '0;
            sq_reg    <= '0;
        end
        if (state_reg == aabb_pkg::ST_MUL) begin
            sq_reg  <= sq_next;
            acc_reg <= acc_next;
            if (cnt_reg == MUL_LAST) begin
                n_reg    <= acc_next[2*W+1:2];
                rem_reg  <= '0;
                root_reg <= '0;
            end
        end
        if (state_reg == aabb_pkg::ST_ROOT) begin
            n_reg <= {n_reg[2*W-3:0], 2'b00};
            if (rem_shift >= trial) begin
                rem_reg  <= rem_shift - trial;
                root_reg <= {root_reg[W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_shift;
                root_reg <= {root_reg[W-2:0], 1'b0};
            end
        end
        if (state_reg == aabb_pkg::ST_DONE && out_free) begin
            m_center_x  <= cen_x_reg;
            m_center_y  <= cen_y_reg;
            m_center_z  <= cen_z_reg;
            m_radius    <= root_reg;
            m_box_min_x <= lo_x_reg;
            m_box_min_y <= lo_y_reg;
            m_box_min_z <= lo_z_reg;
            m_box_max_x <= hi_x_reg;
            m_box_max_y <= hi_y_reg;
            m_box_max_z <= hi_z_reg;
        end
    end

    assign m_valid = m_valid_reg;

    a_done_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == aabb_pkg::ST_DONE && out_free) |=> m_valid_reg)
        else $error("finished item not presented");

    a_root_remainder: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == aabb_pkg::ST_ROOT) |-> (rem_reg <= {1'b0, root_reg, 1'b0}))
        else $error("square root remainder out of range");

endmodule

[hw/rtl/aabb_bounding_sphere.sv]
// Throughput: one vertex per cycle while the two-entry queue of finished boxes between the
// min/max front end and the back end is not full. The back end works on one box at a time
// (three squarings on one multiplier, then one root bit per cycle) and pops the next box
// only once it has passed its result to the output registers.
// Reset: aresetn is synchronous, active low; it clears the box, the queue and the output
// valid and marks the next vertex as the first of a geometry.
module aabb_bounding_sphere #(
    parameter int COORD_BITS = aabb_pkg::COORD_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_pos_x,
    input  logic signed [COORD_BITS-1:0] s_pos_y,
    input  logic signed [COORD_BITS-1:0] s_pos_z,
    input  logic                         s_last_vertex,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [COORD_BITS-1:0] m_center_x,
    output logic signed [COORD_BITS-1:0] m_center_y,
    output logic signed [COORD_BITS-1:0] m_center_z,
    output logic        [COORD_BITS-1:0] m_radius,
    output logic signed [COORD_BITS-1:0] m_box_min_x,
    output logic signed [COORD_BITS-1:0] m_box_min_y,
    output logic signed [COORD_BITS-1:0] m_box_min_z,
    output logic signed [COORD_BITS-1:0] m_box_max_x,
    output logic signed [COORD_BITS-1:0] m_box_max_y,
    output logic signed [COORD_BITS-1:0] m_box_max_z
);

    localparam int BOX_BITS = aabb_pkg::BOX_FIELDS * COORD_BITS;

    aabb_pkg::fifo_status_t fifo_status;
    logic                   push_valid;
    logic [BOX_BITS-1:0]    push_data;
    logic                   pop;
    logic [BOX_BITS-1:0]    pop_data;

    aabb_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_pos_z      (s_pos_z),
        .s_last_vertex(s_last_vertex),
        .fifo_status  (fifo_status),
        .push_valid   (push_valid),
        .push_data    (push_data)
    );

    aabb_fifo #(
        .DATA_BITS(BOX_BITS),
        .DEPTH    (aabb_pkg::FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push_valid),
        .push_data(push_data),
        .pop      (pop),
        .pop_data (pop_data),
        .status   (fifo_status)
    );

    aabb_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fifo_status(fifo_status),
        .box_data   (pop_data),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_center_x (m_center_x),
        .m_center_y (m_center_y),
        .m_center_z (m_center_z),
        .m_radius   (m_radius),
        .m_box_min_x(m_box_min_x),
        .m_box_min_y(m_box_min_y),
        .m_box_min_z(m_box_min_z),
        .m_box_max_x(m_box_max_x),
        .m_box_max_y(m_box_max_y),
        .m_box_max_z(m_box_max_z)
    );

endmodule

[bench/aabb_bounding_sphere_checker.sv]
module aabb_bounding_sphere_checker #(
    parameter int COORD_BITS = aabb_pkg::COORD_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_pos_x,
    input  logic signed [COORD_BITS-1:0] s_pos_y,
    input  logic signed [COORD_BITS-1:0] s_pos_z,
    input  logic                         s_last_vertex,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic signed [COORD_BITS-1:0] m_center_x,
    input  logic signed [COORD_BITS-1:0] m_center_y,
    input  logic signed [COORD_BITS-1:0] m_center_z,
    input  logic        [COORD_BITS-1:0] m_radius,
    input  logic signed [COORD_BITS-1:0] m_box_min_x,
    input  logic signed [COORD_BITS-1:0] m_box_min_y,
    input  logic signed [COORD_BITS-1:0] m_box_min_z,
    input  logic signed [COORD_BITS-1:0] m_box_max_x,
    input  logic signed [COORD_BITS-1:0] m_box_max_y,
    input  logic signed [COORD_BITS-1:0] m_box_max_z,
    output int unsigned                  mismatches,
    output int unsigned                  spheres_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AXES = aabb_pkg::AXES;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [AXES-1:0][COORD_BITS-1:0] center;
        logic [COORD_BITS-1:0]           radius;
        logic [AXES-1:0][COORD_BITS-1:0] low;
        logic [AXES-1:0][COORD_BITS-1:0] high;
    } sphere_t;

    coord_t      low_edge [AXES];
    coord_t      high_edge [AXES];
    bit          first_pending;
    sphere_t     pending_spheres [$];
    int unsigned errors;
    int unsigned owed;
    string       axis_tag [AXES] = '{"x", "y", "z"};

    assign mismatches   = errors;
    assign spheres_owed = owed;

    initial begin
        errors = 0;
        owed   = 0;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = COORD_BITS + 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic bit fold_vertex(input coord_t x, input coord_t y, input coord_t z,
                                       input logic last, output sphere_t sphere);
        coord_t          pos [AXES];
        longint          sq;
        longint unsigned quarter_sum;
        longint unsigned remainder_sum;
        int              total;
        pos[0] = x;
        pos[1] = y;
        pos[2] = z;
        sphere = '0;
        for (int a = 0; a < AXES; a++) begin
            if (first_pending) begin
                low_edge[a]  = pos[a];
                high_edge[a] = pos[a];
            end else begin
                if (pos[a] < low_edge[a]) begin
                    low_edge[a] = pos[a];
                end
                if (pos[a] > high_edge[a]) begin
                    high_edge[a] = pos[a];
                end
            end
        end
        first_pending = last;
        if (!last) begin
            return 1'b0;
        end
        quarter_sum   = 0;
        remainder_sum = 0;
        for (int a = 0; a < AXES; a++) begin
            sq = longint'(high_edge[a]) - longint'(low_edge[a]);
            sq = sq * sq;
            quarter_sum   += sq >> 2;
            remainder_sum += sq & 3;
            total = int'(low_edge[a]) + int'(high_edge[a]);
            sphere.center[a] = COORD_BITS'(total >>> 1);
            sphere.low[a]    = low_edge[a];
            sphere.high[a]   = high_edge[a];
        end
        sphere.radius = COORD_BITS'(int_sqrt(quarter_sum + (remainder_sum >> 2)));
        return 1'b1;
    endfunction

    task automatic check_field(input string what, input logic [COORD_BITS-1:0] want,
                               input logic [COORD_BITS-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected 0x%h, got 0x%h", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch
        sphere_t fresh;
        sphere_t want;
        sphere_t got;
        if (!aresetn) begin
            first_pending = 1'b1;
            for (int a = 0; a < AXES; a++) begin
                low_edge[a]  = '0;
                high_edge[a] = '0;
            end
            pending_spheres.delete();
        end else begin
            if (s_valid && s_ready) begin
                if (fold_vertex(s_pos_x, s_pos_y, s_pos_z, s_last_vertex, fresh)) begin
                    pending_spheres.insert(pending_spheres.size(), fresh);
                end
            end
            if (m_valid && m_ready) begin
                got.center[0] = m_center_x;
                got.center[1] = m_center_y;
                got.center[2] = m_center_z;
                got.radius    = m_radius;
                got.low[0]    = m_box_min_x;
                got.low[1]    = m_box_min_y;
                got.low[2]    = m_box_min_z;
                got.high[0]   = m_box_max_x;
                got.high[1]   = m_box_max_y;
                got.high[2]   = m_box_max_z;
                if (pending_spheres.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got 0x%h", $time, got);
                end else begin
                    want = pending_spheres.pop_front();
                    check_field("radius", want.radius, got.radius);
                    for (int a = 0; a < AXES; a++) begin
                        check_field({"center_", axis_tag[a]}, want.center[a], got.center[a]);
                        check_field({"box_min_", axis_tag[a]}, want.low[a], got.low[a]);
                        check_field({"box_max_", axis_tag[a]}, want.high[a], got.high[a]);
                    end
                end
            end
        end
        owed = pending_spheres.size();
    end

endmodule

[bench/aabb_bounding_sphere_tb.sv]
module aabb_bounding_sphere_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          COORD_BITS  = aabb_pkg::COORD_BITS_DEFAULT;
    localparam int          PERIOD      = 20;
    localparam int          RANDOM_ITEMS = 1900;
    localparam int          PHASES      = 4;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int          DRAIN       = 4 * (COORD_BITS + 6);

    localparam logic [COORD_BITS-1:0] MOST_NEG = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [COORD_BITS-1:0] MOST_POS = {1'b0, {(COORD_BITS-1){1'b1}}};

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic signed [COORD_BITS-1:0] s_pos_x = '0;
    logic signed [COORD_BITS-1:0] s_pos_y = '0;
    logic signed [COORD_BITS-1:0] s_pos_z = '0;
    logic                         s_last_vertex = 1'b0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic signed [COORD_BITS-1:0] m_center_x;
    logic signed [COORD_BITS-1:0] m_center_y;
    logic signed [COORD_BITS-1:0] m_center_z;
    logic        [COORD_BITS-1:0] m_radius;
    logic signed [COORD_BITS-1:0] m_box_min_x;
    logic signed [COORD_BITS-1:0] m_box_min_y;
    logic signed [COORD_BITS-1:0] m_box_min_z;
    logic signed [COORD_BITS-1:0] m_box_max_x;
    logic signed [COORD_BITS-1:0] m_box_max_y;
    logic signed [COORD_BITS-1:0] m_box_max_z;

    int unsigned mismatches;
    int unsigned spheres_owed;
    int unsigned cycles = 0;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned idle_tab [PHASES] = '{0, 81, 0, 6};
    int unsigned stall_tab [PHASES] = '{0, 0, 81, 6};

    aabb_bounding_sphere #(
        .COORD_BITS(COORD_BITS)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_pos_z      (s_pos_z),
        .s_last_vertex(s_last_vertex),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_center_x   (m_center_x),
        .m_center_y   (m_center_y),
        .m_center_z   (m_center_z),
        .m_radius     (m_radius),
        .m_box_min_x  (m_box_min_x),
        .m_box_min_y  (m_box_min_y),
        .m_box_min_z  (m_box_min_z),
        .m_box_max_x  (m_box_max_x),
        .m_box_max_y  (m_box_max_y),
        .m_box_max_z  (m_box_max_z)
    );

    aabb_bounding_sphere_checker #(
        .COORD_BITS(COORD_BITS)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_pos_z      (s_pos_z),
        .s_last_vertex(s_last_vertex),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_center_x   (m_center_x),
        .m_center_y   (m_center_y),
        .m_center_z   (m_center_z),
        .m_radius     (m_radius),
        .m_box_min_x  (m_box_min_x),
        .m_box_min_y  (m_box_min_y),
        .m_box_min_z  (m_box_min_z),
        .m_box_max_x  (m_box_max_x),
        .m_box_max_y  (m_box_max_y),
        .m_box_max_z  (m_box_max_z),
        .mismatches   (mismatches),
        .spheres_owed (spheres_owed)
    );

    always #(PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push_vertex(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                               input logic [COORD_BITS-1:0] z, input logic last);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < idle_pct) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_pos_x       <= x;
        s_pos_y       <= y;
        s_pos_z       <= z;
        s_last_vertex <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic [COORD_BITS-1:0] pick_coord(input int unsigned mode,
                                                         input logic [COORD_BITS-1:0] base);
        case (mode)
            0: begin
                return COORD_BITS'($urandom);
            end
            1: begin
                return COORD_BITS'(base + $urandom_range(511) - 256);
            end
            default: begin
                case ($urandom_range(3))
                    0: return MOST_NEG;
                    1: return MOST_POS;
                    2: return '0;
                    default: return COORD_BITS'($urandom);
                endcase
            end
        endcase
    endfunction

    initial begin
        int unsigned            sent;
        int unsigned            length;
        int unsigned            mode;
        logic [COORD_BITS-1:0]  base [3];

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        push_vertex(MOST_NEG, MOST_NEG, MOST_NEG, 1'b1);
        push_vertex(MOST_POS, MOST_POS, MOST_POS, 1'b1);
        push_vertex('0, '0, '0, 1'b1);
        push_vertex(MOST_NEG, MOST_NEG, MOST_NEG, 1'b0);
        push_vertex(MOST_POS, MOST_POS, MOST_POS, 1'b1);
        push_vertex(COORD_BITS'(-3), COORD_BITS'(5), COORD_BITS'(-1), 1'b0);
        push_vertex('0, COORD_BITS'(-2), '0, 1'b1);
        push_vertex(COORD_BITS'(100), COORD_BITS'(-7), COORD_BITS'(3), 1'b0);
        push_vertex(COORD_BITS'(-50), COORD_BITS'(20), COORD_BITS'(8), 1'b0);
        push_vertex(COORD_BITS'(12), COORD_BITS'(12), COORD_BITS'(-40), 1'b0);
        push_vertex(COORD_BITS'(300), COORD_BITS'(-300), COORD_BITS'(1), 1'b0);
        push_vertex('0, '0, '0, 1'b1);
        push_vertex(MOST_POS, MOST_NEG, COORD_BITS'(1), 1'b0);
        push_vertex(MOST_NEG, MOST_POS, COORD_BITS'(-1), 1'b1);
        push_vertex(16'h5555, 16'haaaa, COORD_BITS'(1), 1'b1);
        push_vertex(16'haaaa, 16'h5555, COORD_BITS'(-2), 1'b0);
        push_vertex(16'h5555, 16'haaaa, 16'h7ffe, 1'b1);

        sent = 0;
        for (int p = 0; p < PHASES; p++) begin
            idle_pct  = idle_tab[p];
            stall_pct = stall_tab[p];
            while (sent < (p + 1) * RANDOM_ITEMS / PHASES) begin
                case ($urandom_range(9))
                    0: length = 1;
                    8: length = $urandom_range(20, 7);
                    9: length = $urandom_range(60, 30);
                    default: length = $urandom_range(6, 2);
                endcase
                mode = $urandom_range(2);
                for (int a = 0; a < 3; a++) begin
                    base[a] = COORD_BITS'($urandom);
                end
                for (int k = 0; k < length; k++) begin
                    push_vertex(pick_coord(mode, base[0]), pick_coord(mode, base[1]),
                                pick_coord(mode, base[2]), k == length - 1);
                end
                sent += length;
            end
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (spheres_owed != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/aabb_pkg.sv
hw/rtl/aabb_front.sv
hw/rtl/aabb_fifo.sv
hw/rtl/aabb_back.sv
hw/rtl/aabb_bounding_sphere.sv
bench/aabb_bounding_sphere_checker.sv
bench/aabb_bounding_sphere_tb.sv
